// ----- src/rse_pkg.sv -----
package rse_pkg;

  localparam int          MAX_DEGREE_DEF = 30;
  localparam int          RESET_DEGREE   = 10;
  localparam int          CFG_W          = 5;
  // low byte of x^8 + x^4 + x^3 + x^2 + 1
  localparam logic [7:0]  FIELD_POLY_LOW = 8'h1D;
  localparam logic [7:0]  ROOT_STEP      = 8'h02;

  typedef struct packed {
    logic gen_init;  // load the starting generator (monic term only)
    logic gen_step;  // multiply generator by (x + root)
    logic shift;     // remainder moves one cell toward the head
    logic clear;     // remainder to zero
  } ctl_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 7; i >= 0; i--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? FIELD_POLY_LOW : 8'h00);
      if (b[i]) acc = acc ^ a;
    end
    return acc;
  endfunction

endpackage

// ----- src/rse_cell.sv -----
module rse_cell (
  input  logic          clk,
  input  rse_pkg::ctl_t ctl,
  input  logic [7:0]    mul_op,
  input  logic          init_one,
  input  logic [7:0]    g_in,
  input  logic [7:0]    r_in,
  output logic [7:0]    g_out,
  output logic [7:0]    r_out
);
  import rse_pkg::*;

  logic [7:0] g;
  logic [7:0] r;
  logic [7:0] prod;

  // one multiplier per cell, shared by generator build and encoding
  assign prod = gf_mul(g, mul_op);

  always_ff @(posedge clk) begin
    if (ctl.gen_init) begin
      g <= init_one ? 8'h01 : 8'h00;
    end else if (ctl.gen_step) begin
      g <= prod ^ g_in;
    end
    if (ctl.clear) begin
      r <= 8'h00;
    end else if (ctl.shift) begin
      r <= r_in ^ prod;
    end
  end

  assign g_out = g;
  assign r_out = r;

endmodule

// ----- src/reed_solomon_ecc_encoder.sv -----
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D.
// Message bytes are taken one per cycle while in_ready is high; the byte with
// is_last set is followed by degree parity bytes, leading byte first, one
// per cycle as out_ready allows, with parity_last on the final one. No message
// byte is taken until the parity run has drained. The remainder lives in a row
// of MAX_DEGREE cells, each with its own GF(256) multiplier, all updated in the
// same cycle. After reset or a cfg_data write (0 reads as 1, above MAX_DEGREE
// as MAX_DEGREE) the generator polynomial is rebuilt in the same cells, in
// ST_INIT and then ST_GEN, during which in_ready is low; a write also drops
// any partial message.
module reed_solomon_ecc_encoder #(
  parameter int MAX_DEGREE = rse_pkg::MAX_DEGREE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [rse_pkg::CFG_W-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               data_byte,
  input  logic                     is_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               parity_byte,
  output logic                     parity_last
);
  import rse_pkg::*;

  localparam int DW   = $clog2(MAX_DEGREE + 1);
  localparam int CMPW = (DW > CFG_W) ? DW : CFG_W;
  localparam int RST_DEG = (RESET_DEGREE > MAX_DEGREE) ? MAX_DEGREE : RESET_DEGREE;

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_GEN  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]    state;
  logic [DW-1:0] degree;
  logic [DW-1:0] cnt;
  logic [7:0]    root;
  logic [DW-1:0] degree_next;
  logic [CMPW-1:0] cfg_wide;

  logic in_fire;
  logic out_fire;
  logic cfg_fire;
  logic at_end;
  ctl_t ctl;
  logic [7:0] mul_op;

  logic [7:0] g_chain [0:MAX_DEGREE];
  logic [7:0] r_chain [0:MAX_DEGREE];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_RUN);
  assign out_valid = (state == ST_EMIT);
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_fire   = in_valid & in_ready;
  assign out_fire  = out_valid & out_ready;
  assign at_end    = (cnt == degree - DW'(1));

  assign parity_byte = r_chain[0];
  assign parity_last = at_end;

  always_comb begin
    cfg_wide = CMPW'(cfg_data);
    if (cfg_wide == '0) begin
      degree_next = DW'(1);
    end else if (cfg_wide > CMPW'(MAX_DEGREE)) begin
      degree_next = DW'(MAX_DEGREE);
    end else begin
      degree_next = DW'(cfg_wide);
    end
  end

  always_comb begin
    ctl.gen_init = (state == ST_INIT);
    ctl.gen_step = (state == ST_GEN);
    ctl.clear    = (state == ST_INIT);
    ctl.shift    = in_fire | out_fire;
    // emitting shifts with a zero factor, which also leaves the remainder clear
    if (state == ST_GEN) begin
      mul_op = root;
    end else if (in_fire) begin
      mul_op = data_byte ^ r_chain[0];
    end else begin
      mul_op = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_INIT;
      degree <= DW'(RST_DEG);
      cnt    <= '0;
    end else if (cfg_fire) begin
      state  <= ST_INIT;
      degree <= degree_next;
      cnt    <= '0;
    end else begin
      case (state)
        ST_INIT: begin
          state <= ST_GEN;
          cnt   <= '0;
        end
        ST_GEN: begin
          if (at_end) begin
            state <= ST_RUN;
            cnt   <= '0;
          end else begin
            cnt <= cnt + DW'(1);
          end
        end
        ST_RUN: begin
          if (in_fire && is_last) begin
            state <= ST_EMIT;
            cnt   <= '0;
          end
        end
        ST_EMIT: begin
          if (out_fire) begin
            if (at_end) begin
              state <= ST_RUN;
              cnt   <= '0;
            end else begin
              cnt <= cnt + DW'(1);
            end
          end
        end
        default: begin
          state <= ST_INIT;
          cnt   <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_INIT) begin
      root <= 8'h01;
    end else if (state == ST_GEN) begin
      root <= gf_mul(root, ROOT_STEP);
    end
  end

  assign g_chain[MAX_DEGREE] = 8'h00;
  assign r_chain[MAX_DEGREE] = 8'h00;

  for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_cells
    rse_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .mul_op   (mul_op),
      .init_one (DW'(j) == degree - DW'(1)),
      .g_in     (g_chain[j+1]),
      .r_in     (r_chain[j+1]),
      .g_out    (g_chain[j]),
      .r_out    (r_chain[j])
    );
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import rse_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = MAX_DEGREE_DEF + 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 6;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;      // message byte, or degree in the low bits
    logic       last;
    logic       fixed;      // every parity byte of the message is fixed_val
    logic [7:0] fixed_val;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       plast;
  } parity_t;

  localparam stim_row_t DIRECTED [22] = '{
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 8'h00},  // zero message, reset degree
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h01, 1'b1, 1'b0, 8'h00},
    '{ROW_CFG,  8'd1,  1'b0, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 8'h00},  // degree 1: parity equals the byte
    '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 8'hFF},
    '{ROW_BYTE, 8'hA5, 1'b1, 1'b1, 8'hA5},
    '{ROW_BYTE, 8'h5A, 1'b0, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h3C, 1'b1, 1'b0, 8'h00},
    '{ROW_CFG,  8'd0,  1'b0, 1'b0, 8'h00},  // zero taken as one
    '{ROW_BYTE, 8'h77, 1'b1, 1'b1, 8'h77},
    '{ROW_CFG,  8'd31, 1'b0, 1'b0, 8'h00},  // above max, clamped
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_BYTE, 8'hFF, 1'b1, 1'b0, 8'h00},
    '{ROW_CFG,  8'd30, 1'b0, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h12, 1'b0, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h34, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  8'd10, 1'b0, 1'b0, 8'h00},  // partial message must be dropped
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 8'h00}
  };

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       data_byte = '0;
  logic             is_last = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       parity_byte;
  logic             parity_last;

  // encoder state as predicted
  logic [7:0] enc_gen [MAX_DEGREE_DEF];
  logic [7:0] enc_rem [MAX_DEGREE_DEF];
  int         enc_deg;

  parity_t parity_due [$];
  int      mismatches = 0;
  int      parity_checked = 0;
  int      bytes_sent = 0;
  int      messages_done = 0;
  int      degree_writes = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      hold_req = 0;

  reed_solomon_ecc_encoder u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .parity_byte (parity_byte),
    .parity_last (parity_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // GF(256) product, low bit of b first
  function automatic logic [7:0] gf256_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] prod;
    logic [7:0] run;
    prod = '0;
    run  = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) prod = prod ^ run;
      run = run[7] ? ({run[6:0], 1'b0} ^ FIELD_POLY_LOW) : {run[6:0], 1'b0};
    end
    return prod;
  endfunction

  task automatic set_degree(input int raw);
    logic [7:0] root;
    enc_deg = (raw < 1) ? 1 : (raw > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : raw;
    for (int i = 0; i < MAX_DEGREE_DEF; i++) begin
      enc_rem[i] = '0;
      enc_gen[i] = '0;
    end
    enc_gen[enc_deg-1] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < enc_deg; i++) begin
      for (int j = 0; j < enc_deg; j++) begin
        enc_gen[j] = gf256_times(enc_gen[j], root);
        if (j + 1 < enc_deg) enc_gen[j] = enc_gen[j] ^ enc_gen[j+1];
      end
      root = gf256_times(root, ROOT_STEP);
    end
  endtask

  task automatic absorb_byte(input logic [7:0] dbyte, input logic last,
                             input logic fixed, input logic [7:0] fixed_val);
    logic [7:0] factor;
    parity_t    p;
    factor = dbyte ^ enc_rem[0];
    for (int i = 0; i + 1 < enc_deg; i++) enc_rem[i] = enc_rem[i+1];
    enc_rem[enc_deg-1] = '0;
    for (int i = 0; i < enc_deg; i++) enc_rem[i] = enc_rem[i] ^ gf256_times(enc_gen[i], factor);
    if (last) begin
      for (int i = 0; i < enc_deg; i++) begin
        p.pbyte = fixed ? fixed_val : enc_rem[i];
        p.plast = (i + 1 == enc_deg);
        parity_due = {parity_due, p};
        enc_rem[i] = '0;
      end
      messages_done++;
    end
  endtask

  task automatic send_byte(input logic [7:0] dbyte, input logic last,
                           input logic fixed, input logic [7:0] fixed_val);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= dbyte;
    is_last   <= last;
    do @(posedge clk); while (!in_ready);
    absorb_byte(dbyte, last, fixed, fixed_val);
    bytes_sent++;
  endtask

  // only while nothing is owed; the settle covers work on bytes without results
  task automatic write_degree(input logic [CFG_W-1:0] raw);
    in_valid <= 1'b0;
    while (parity_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= raw;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    set_degree(raw);
    degree_writes++;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    parity_t want;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (parity_due.size() == 0) begin
          $display("%0t: unexpected parity item: expected none, actual byte %h last %b",
                   $time, parity_byte, parity_last);
          mismatches++;
        end else begin
          want = parity_due.pop_front();
          parity_checked++;
          if (parity_byte !== want.pbyte) begin
            $display("%0t: parity_byte mismatch: expected %h, actual %h",
                     $time, want.pbyte, parity_byte);
            mismatches++;
          end
          if (parity_last !== want.plast) begin
            $display("%0t: parity_last mismatch: expected %b, actual %b",
                     $time, want.plast, parity_last);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles, %0d parity items still owed",
             $time, WATCHDOG_LIMIT, parity_due.size());
    $display("reed_solomon_ecc_encoder test failed");
    $finish;
  end

  initial begin
    int sent;
    int len;
    logic [CFG_W-1:0] raw;
    set_degree(RESET_DEGREE);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < $size(DIRECTED); r++) begin
      if (DIRECTED[r].kind == ROW_CFG)
        write_degree(DIRECTED[r].value[CFG_W-1:0]);
      else
        send_byte(DIRECTED[r].value, DIRECTED[r].last, DIRECTED[r].fixed,
                  DIRECTED[r].fixed_val);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 64; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 64; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      case (p)
        0: raw = 5'd30;
        1: raw = 5'd1;
        2: raw = CFG_W'($urandom_range(2, 29));
        3: raw = 5'd31;
        4: raw = CFG_W'($urandom_range(0, 31));
        default: raw = 5'd10;
      endcase
      write_degree(raw);
      // long receiver hold-off: parity backs up and the input stalls
      if (p == 0) hold_req = HOLD_CYCLES;
      sent = 0;
      while (sent < 20) begin
        len = (p == 0) ? 10 : $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          send_byte(8'($urandom_range(0, 255)), k == len - 1, 1'b0, 8'h00);
        sent += len;
      end
      // leave a message unfinished; the next degree write drops it
      if (p == 2 || p == 4)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 8'h00);
    end

    in_valid <= 1'b0;
    while (parity_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d message bytes in %0d messages over %0d degree settings,",
             bytes_sent, messages_done, degree_writes + 1);
    $display("checked %0d parity items, %0d mismatches.", parity_checked, mismatches);
    if (mismatches == 0 && parity_due.size() == 0)
      $display("reed_solomon_ecc_encoder test passed");
    else
      $display("reed_solomon_ecc_encoder test failed");
    $finish;
  end

endmodule
